FILE: src/jsu8_pkg.sv
// Shared types and constants of the JSON string UTF-8 decoder.
// Depends on nothing; every other file imports it.
`default_nettype none

package jsu8_pkg;

   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_QUOTE = 8'h22;
   localparam logic [7:0] CHAR_AT    = 8'h40;

   localparam logic [7:0] LEAD_2 = 8'h80;
   localparam logic [7:0] LEAD_3 = 8'hE0;
   localparam logic [7:0] LEAD_4 = 8'hF0;
   localparam logic [7:0] LEAD_5 = 8'hF8;
   localparam logic [7:0] LEAD_6 = 8'hFC;
   localparam logic [7:0] LEAD_BAD = 8'hFE;
   localparam logic [7:0] CONT_END = 8'hC0;

   localparam logic [2:0] NARROW_MAX_LEN = 3'd3;
   localparam logic [15:0] MAX_CHARS = 16'hFFFF;

   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic [1:0] {
      PH_WAIT_QUOTE = 2'd0,
      PH_WAIT_AT    = 2'd1,
      PH_BODY       = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_CHAR = 2'd0,
      KIND_END  = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_UTF8  = 2'd1,
      ERR_BIG   = 2'd2,
      ERR_MATCH = 2'd3
   } err_type;

   typedef enum logic {
      CSR_ATTR_MODE   = 1'b0,
      CSR_NARROW_MODE = 1'b1
   } csr_index_type;

   // One classified input byte; lead_len of zero marks a byte of 0xFE or above.
   typedef struct packed {
      logic       is_space;
      logic       is_quote;
      logic       is_at;
      logic       is_cont;
      logic [2:0] lead_len;
      logic [6:0] lead_val;
      logic [5:0] cont_val;
   } byte_class_type;

   typedef struct packed {
      kind_type    kind;
      logic [30:0] code_point;
      logic [15:0] char_count;
      err_type     error_code;
   } result_type;

   typedef struct packed {
      logic attr_mode;
      logic narrow_mode;
   } mode_type;

endpackage

`default_nettype wire

FILE: src/jsu8_front.sv
// Front end: classifies each raw byte for the decode back end.
// Depends on jsu8_pkg.
`default_nettype none

module jsu8_front (
   input  wire logic [7:0]              in_byte,
   output jsu8_pkg::byte_class_type     cls
);
   import jsu8_pkg::*;

   always_comb begin
      cls          = '0;
      cls.is_space = (in_byte == CHAR_SPACE) || (in_byte == CHAR_TAB) ||
                     (in_byte == CHAR_LF) || (in_byte == CHAR_CR);
      cls.is_quote = (in_byte == CHAR_QUOTE);
      cls.is_at    = (in_byte == CHAR_AT);
      cls.is_cont  = (in_byte >= LEAD_2) && (in_byte < CONT_END);
      cls.cont_val = in_byte[5:0];
      if (in_byte < LEAD_2) begin
         cls.lead_len = 3'd1;
         cls.lead_val = in_byte[6:0];
      end else if (in_byte < LEAD_3) begin
         cls.lead_len = 3'd2;
         cls.lead_val = {2'b0, in_byte[4:0]};
      end else if (in_byte < LEAD_4) begin
         cls.lead_len = 3'd3;
         cls.lead_val = {3'b0, in_byte[3:0]};
      end else if (in_byte < LEAD_5) begin
         cls.lead_len = 3'd4;
         cls.lead_val = {4'b0, in_byte[2:0]};
      end else if (in_byte < LEAD_6) begin
         cls.lead_len = 3'd5;
         cls.lead_val = {5'b0, in_byte[1:0]};
      end else if (in_byte < LEAD_BAD) begin
         cls.lead_len = 3'd6;
         cls.lead_val = {6'b0, in_byte[0]};
      end else begin
         cls.lead_len = 3'd0;
         cls.lead_val = 7'd0;
      end
   end

endmodule

`default_nettype wire

FILE: src/jsu8_queue.sv
// Short queue of classified bytes between front and back end.
// Depends on jsu8_pkg.
`default_nettype none

module jsu8_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire jsu8_pkg::byte_class_type wdata,
   output logic                         full,
   input  wire logic                    pop,
   output logic                         empty,
   output jsu8_pkg::byte_class_type     rdata
);
   import jsu8_pkg::*;

   byte_class_type         slot_ff [CMD_DEPTH];
   logic [CMD_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [CMD_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CMD_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == CMD_CNT_W'(CMD_DEPTH));
   assign empty   = (count_ff == '0);
   assign rdata   = slot_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

`default_nettype wire

FILE: src/jsu8_back.sv
// Back end: string state machine, UTF-8 assembly and a two-entry result queue.
// Depends on jsu8_pkg.
`default_nettype none

module jsu8_back (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire jsu8_pkg::mode_type      mode,
   input  wire logic                    cmd_empty,
   input  wire jsu8_pkg::byte_class_type cmd,
   output logic                         cmd_pop,
   output logic                         rsp_empty,
   input  wire logic                    rsp_pop,
   output jsu8_pkg::result_type         rsp
);
   import jsu8_pkg::*;

   phase_type    phase_ff, phase_in;
   logic [2:0]   octets_ff, octets_in;
   logic [2:0]   seq_len_ff, seq_len_in;
   logic [30:0]  partial_ff, partial_in;
   logic [15:0]  count_ff, count_in;

   result_type   res;
   logic         res_valid;
   logic         done;
   logic [2:0]   octets_next;

   result_type   out_ff [2];
   logic         out_wr_ff, out_wr_in;
   logic         out_rd_ff, out_rd_in;
   logic [1:0]   out_cnt_ff, out_cnt_in;
   logic         out_pop;
   logic         out_space;

   assign rsp_empty = (out_cnt_ff == 2'd0);
   assign rsp       = out_ff[out_rd_ff];
   assign out_pop   = rsp_pop && !rsp_empty;
   assign out_space = (out_cnt_ff != 2'd2) || out_pop;
   assign cmd_pop   = !cmd_empty && out_space;
   assign octets_next = octets_ff + 3'd1;

   always_comb begin
      phase_in   = phase_ff;
      octets_in  = octets_ff;
      seq_len_in = seq_len_ff;
      partial_in = partial_ff;
      count_in   = count_ff;
      res        = '{kind: KIND_CHAR, code_point: '0, char_count: '0, error_code: ERR_NONE};
      res_valid  = 1'b0;
      done       = 1'b0;
      if (cmd_pop) begin
         case (phase_ff)
            PH_WAIT_QUOTE: begin
               if (cmd.is_quote) begin
                  count_in   = '0;
                  octets_in  = '0;
                  seq_len_in = '0;
                  partial_in = '0;
                  phase_in   = mode.attr_mode ? PH_WAIT_AT : PH_BODY;
               end else if (!cmd.is_space) begin
                  count_in       = '0;
                  octets_in      = '0;
                  seq_len_in     = '0;
                  partial_in     = '0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERR;
                  res.error_code = ERR_MATCH;
               end
            end
            PH_WAIT_AT: begin
               if (cmd.is_at) begin
                  phase_in = PH_BODY;
               end else begin
                  phase_in       = PH_WAIT_QUOTE;
                  octets_in      = '0;
                  seq_len_in     = '0;
                  partial_in     = '0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERR;
                  res.char_count = count_ff;
                  res.error_code = ERR_MATCH;
               end
            end
            PH_BODY: begin
               if (cmd.is_quote) begin
                  // drop any partial character
                  phase_in       = PH_WAIT_QUOTE;
                  octets_in      = '0;
                  seq_len_in     = '0;
                  partial_in     = '0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_END;
                  res.char_count = count_ff;
               end else if (octets_ff == 3'd0) begin
                  if (cmd.lead_len == 3'd0) begin
                     phase_in       = PH_WAIT_QUOTE;
                     octets_in      = '0;
                     seq_len_in     = '0;
                     partial_in     = '0;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERR;
                     res.char_count = count_ff;
                     res.error_code = ERR_UTF8;
                  end else if (mode.narrow_mode && (cmd.lead_len > NARROW_MAX_LEN)) begin
                     phase_in       = PH_WAIT_QUOTE;
                     octets_in      = '0;
                     seq_len_in     = '0;
                     partial_in     = '0;
                     res_valid      = 1'b1;
                     res.kind       = KIND_ERR;
                     res.char_count = count_ff;
                     res.error_code = ERR_BIG;
                  end else begin
                     seq_len_in = cmd.lead_len;
                     partial_in = {24'd0, cmd.lead_val};
                     octets_in  = 3'd1;
                     done       = (cmd.lead_len == 3'd1);
                  end
               end else if (cmd.is_cont) begin
                  partial_in = {partial_ff[24:0], cmd.cont_val};
                  octets_in  = octets_next;
                  done       = (octets_next >= seq_len_ff);
               end else begin
                  phase_in       = PH_WAIT_QUOTE;
                  octets_in      = '0;
                  seq_len_in     = '0;
                  partial_in     = '0;
                  res_valid      = 1'b1;
                  res.kind       = KIND_ERR;
                  res.char_count = count_ff;
                  res.error_code = ERR_UTF8;
               end
            end
            default: begin
               phase_in   = PH_WAIT_QUOTE;
               octets_in  = '0;
               seq_len_in = '0;
               partial_in = '0;
            end
         endcase
         if (done) begin
            // saturate the count, emit and clear the sequence
            count_in       = (count_ff != MAX_CHARS) ? count_ff + 16'd1 : count_ff;
            res_valid      = 1'b1;
            res.kind       = KIND_CHAR;
            res.code_point = partial_in;
            res.char_count = count_in;
            octets_in      = '0;
            seq_len_in     = '0;
            partial_in     = '0;
         end
      end
   end

   always_comb begin
      out_wr_in  = res_valid ? ~out_wr_ff : out_wr_ff;
      out_rd_in  = out_pop ? ~out_rd_ff : out_rd_ff;
      out_cnt_in = out_cnt_ff;
      if (res_valid && !out_pop) begin
         out_cnt_in = out_cnt_ff + 2'd1;
      end else if (out_pop && !res_valid) begin
         out_cnt_in = out_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_WAIT_QUOTE;
         octets_ff  <= '0;
         seq_len_ff <= '0;
         partial_ff <= '0;
         count_ff   <= '0;
         out_wr_ff  <= 1'b0;
         out_rd_ff  <= 1'b0;
         out_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         octets_ff  <= octets_in;
         seq_len_ff <= seq_len_in;
         partial_ff <= partial_in;
         count_ff   <= count_in;
         out_wr_ff  <= out_wr_in;
         out_rd_ff  <= out_rd_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         out_ff[out_wr_ff] <= res;
      end
   end

endmodule

`default_nettype wire

FILE: src/json_string_utf8_decoder.sv
// Top level of the JSON string UTF-8 decoder: mode registers and the three parts.
// Depends on jsu8_pkg, jsu8_front, jsu8_queue and jsu8_back.
//
// The decoder takes one byte per cycle and sustains that rate indefinitely
// while rsp_pop keeps up: a pushed byte is registered in a four-entry byte
// queue, is decoded by the string state machine when it leaves the queue,
// and its result (if any) is registered for the rsp_ ports.
// The state machine in the back end sets the rate; the byte
// queue and a two-entry result queue let input and output stall apart.
// Each byte gives zero or one result: a decoded character with the running
// count, the end of a string, or an error. csr_ready is always high; write
// attr_mode (index 0) and narrow_mode (index 1) only while no bytes or
// results are in flight. No clearing pass follows reset.
`default_nettype none

module json_string_utf8_decoder (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_push,
   output logic             req_full,
   input  wire logic [7:0]  req_in_byte,
   output logic             rsp_empty,
   input  wire logic        rsp_pop,
   output logic [1:0]       rsp_kind,
   output logic [30:0]      rsp_code_point,
   output logic [15:0]      rsp_char_count,
   output logic [1:0]       rsp_error_code,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic        csr_data
);
   import jsu8_pkg::*;

   mode_type        mode_ff, mode_in;
   byte_class_type  front_cls;
   byte_class_type  cmd;
   logic            cmd_empty;
   logic            cmd_pop;
   result_type      rsp;

   assign csr_ready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_ATTR_MODE:   mode_in.attr_mode   = csr_data;
            CSR_NARROW_MODE: mode_in.narrow_mode = csr_data;
            default:         mode_in = mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= '0;
      end else begin
         mode_ff <= mode_in;
      end
   end

   jsu8_front u_front (
      .in_byte (req_in_byte),
      .cls     (front_cls)
   );

   jsu8_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (req_push),
      .wdata (front_cls),
      .full  (req_full),
      .pop   (cmd_pop),
      .empty (cmd_empty),
      .rdata (cmd)
   );

   jsu8_back u_back (
      .clock     (clock),
      .reset     (reset),
      .mode      (mode_ff),
      .cmd_empty (cmd_empty),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp)
   );

   assign rsp_kind       = rsp.kind;
   assign rsp_code_point = rsp.code_point;
   assign rsp_char_count = rsp.char_count;
   assign rsp_error_code = rsp.error_code;

endmodule

`default_nettype wire

FILE: src/jsu8_checker.sv
// Port-level checks of json_string_utf8_decoder and the bind that attaches them.
// Depends on jsu8_pkg and the top level's ports.
`default_nettype none

module jsu8_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [1:0]  rsp_kind,
   input wire logic [30:0] rsp_code_point,
   input wire logic [15:0] rsp_char_count,
   input wire logic [1:0]  rsp_error_code,
   input wire logic        csr_valid,
   input wire logic        csr_ready
);
   import jsu8_pkg::*;

   // both queues come out of reset empty
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");

   // a waiting word holds until popped
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_kind) && $stable(rsp_code_point) &&
          $stable(rsp_char_count) && $stable(rsp_error_code)))
      else $error("result word changed while waiting");

   // a decoded character always counts itself and carries no error
   a_char_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_kind == KIND_CHAR)) |->
         ((rsp_char_count != 16'd0) && (rsp_error_code == ERR_NONE)))
      else $error("bad character word");

   // errors name a cause and carry no code point
   a_err_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_kind == KIND_ERR)) |->
         ((rsp_error_code != ERR_NONE) && (rsp_code_point == 31'd0)))
      else $error("bad error word");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("register write stalled");

endmodule

bind json_string_utf8_decoder jsu8_checker u_jsu8_checker (
   .clock          (clock),
   .reset          (reset),
   .req_full       (req_full),
   .rsp_empty      (rsp_empty),
   .rsp_pop        (rsp_pop),
   .rsp_kind       (rsp_kind),
   .rsp_code_point (rsp_code_point),
   .rsp_char_count (rsp_char_count),
   .rsp_error_code (rsp_error_code),
   .csr_valid      (csr_valid),
   .csr_ready      (csr_ready)
);

`default_nettype wire
